// ===== sv/bclc_pkg.sv =====
// Shared types, key codes and defaults for the key-chord level control.
package bclc_pkg;

  // Key identifiers as they arrive on key_id
  localparam logic [3:0] KEY_MENU   = 4'd0;
  localparam logic [3:0] KEY_PWR    = 4'd1;
  localparam logic [3:0] KEY_SELECT = 4'd2;
  localparam logic [3:0] KEY_START  = 4'd3;
  localparam logic [3:0] KEY_L1     = 4'd4;
  localparam logic [3:0] KEY_L2     = 4'd5;
  localparam logic [3:0] KEY_MINUS  = 4'd6;
  localparam logic [3:0] KEY_R1     = 4'd7;
  localparam logic [3:0] KEY_R2     = 4'd8;
  localparam logic [3:0] KEY_PLUS   = 4'd9;

  // Key values as they arrive on key_value
  localparam logic [1:0] VAL_RELEASED = 2'd0;
  localparam logic [1:0] VAL_PRESSED  = 2'd1;
  localparam logic [1:0] VAL_REPEAT   = 2'd2;

  // Level limits
  localparam int VOLUME_MAX_DEF     = 20;
  localparam int BRIGHTNESS_MAX_DEF = 10;

  // Port widths
  localparam int VOLUME_W     = 5;
  localparam int BRIGHTNESS_W = 4;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET_MENU,
    OP_SET_POWER,
    OP_SET_SELECT,
    OP_SET_START,
    OP_LEVEL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic press;  // held value for modifiers, pressed for level keys
    logic rpt;    // level key repeat
    logic up;     // level key steps upwards
    logic plus;   // model with dedicated volume keys
  } cmd_t;

endpackage

// ===== sv/bclc_front.sv =====
// Front end: holds the model register, accepts key events and classifies them.
module bclc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_data,
  input  logic [3:0]      key_id,
  input  logic [1:0]      key_value,
  output bclc_pkg::cmd_t  cmd
);
  import bclc_pkg::*;

  logic plus_model;
  logic active;

  // Model register
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_model <= 1'b0;
    end else if (cfg_write) begin
      plus_model <= cfg_data;
    end
  end

  // Shoulder keys are dead on the plus model
  assign active = !plus_model || (key_id == KEY_MINUS) || (key_id == KEY_PLUS);

  // Event decode
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.press = (key_value == VAL_PRESSED);
    cmd.rpt   = (key_value == VAL_REPEAT);
    cmd.up    = 1'b0;
    cmd.plus  = plus_model;
    if (key_value != VAL_RELEASED && key_value != VAL_PRESSED &&
        key_value != VAL_REPEAT) begin
      cmd.op = OP_NONE;
    end else begin
      unique case (key_id) inside
        KEY_MENU: begin
          cmd.op = cmd.rpt ? OP_NONE : OP_SET_MENU;
        end
        KEY_PWR: begin
          cmd.op = cmd.rpt ? OP_NONE : OP_SET_POWER;
        end
        KEY_SELECT: begin
          cmd.op = cmd.rpt ? OP_NONE : OP_SET_SELECT;
        end
        KEY_START: begin
          cmd.op = cmd.rpt ? OP_NONE : OP_SET_START;
        end
        KEY_L1, KEY_L2, KEY_MINUS: begin
          cmd.op = active ? OP_LEVEL : OP_NONE;
        end
        KEY_R1, KEY_R2, KEY_PLUS: begin
          cmd.op = active ? OP_LEVEL : OP_NONE;
          cmd.up = 1'b1;
        end
        default: begin
          cmd.op = OP_NONE;
        end
      endcase
    end
  end

endmodule

// ===== sv/bclc_queue.sv =====
// Short command queue between the front and back ends.
module bclc_queue #(
  parameter int DEPTH = bclc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bclc_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output bclc_pkg::cmd_t  head_cmd,
  output logic            full,
  output logic            empty
);
  import bclc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = entry[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/bclc_back.sv =====
// Back end: key-held flags, repeat toggle, clamped levels and the result register.
module bclc_back #(
  parameter int MAX_VOLUME     = bclc_pkg::VOLUME_MAX_DEF,
  parameter int MAX_BRIGHTNESS = bclc_pkg::BRIGHTNESS_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bclc_pkg::cmd_t                    cmd,
  input  logic                              cmd_avail,
  output logic                              cmd_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bclc_pkg::VOLUME_W-1:0]     volume_level,
  output logic [bclc_pkg::BRIGHTNESS_W-1:0] brightness_level,
  output logic                              shutdown_request
);
  import bclc_pkg::*;

  logic                    menu_held, power_held, select_held, start_held;
  logic                    repeat_phase;
  logic [VOLUME_W-1:0]     volume;
  logic [BRIGHTNESS_W-1:0] brightness;
  logic                    shut;

  logic                    menu_held_next, power_held_next;
  logic                    select_held_next, start_held_next;
  logic                    repeat_phase_next;
  logic [VOLUME_W-1:0]     volume_next;
  logic [BRIGHTNESS_W-1:0] brightness_next;
  logic                    shut_next;
  logic                    eff, vol_sel, bri_sel;

  // Advance when the result slot is free or being taken
  assign cmd_pop = cmd_avail && (!out_valid || !out_stall);

  // Execute one command
  always_comb begin
    menu_held_next    = menu_held;
    power_held_next   = power_held;
    select_held_next  = select_held;
    start_held_next   = start_held;
    repeat_phase_next = repeat_phase;
    volume_next       = volume;
    brightness_next   = brightness;
    eff               = 1'b0;
    vol_sel           = 1'b0;
    bri_sel           = 1'b0;

    unique case (cmd.op)
      OP_SET_MENU:   menu_held_next   = cmd.press;
      OP_SET_POWER:  power_held_next  = cmd.press;
      OP_SET_SELECT: select_held_next = cmd.press;
      OP_SET_START:  start_held_next  = cmd.press;
      OP_LEVEL: begin
        // every second repeat counts as a press
        if (cmd.rpt) begin
          eff               = repeat_phase;
          repeat_phase_next = !repeat_phase;
        end else begin
          eff               = cmd.press;
          repeat_phase_next = 1'b0;
        end
        vol_sel = (cmd.plus && !menu_held) || (select_held && !start_held);
        bri_sel = (cmd.plus && menu_held) || (start_held && !select_held);
        if (eff && vol_sel) begin
          if (cmd.up) begin
            if (volume < VOLUME_W'(MAX_VOLUME)) volume_next = volume + 1'b1;
          end else if (volume != '0) begin
            volume_next = volume - 1'b1;
          end
        end else if (eff && bri_sel) begin
          if (cmd.up) begin
            if (brightness < BRIGHTNESS_W'(MAX_BRIGHTNESS)) begin
              brightness_next = brightness + 1'b1;
            end
          end else if (brightness != '0) begin
            brightness_next = brightness - 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Menu and power together: shutdown pulse, both flags dropped
    shut_next = menu_held_next && power_held_next;
    if (shut_next) begin
      menu_held_next  = 1'b0;
      power_held_next = 1'b0;
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      menu_held    <= 1'b0;
      power_held   <= 1'b0;
      select_held  <= 1'b0;
      start_held   <= 1'b0;
      repeat_phase <= 1'b0;
      volume       <= '0;
      brightness   <= '0;
      shut         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        menu_held    <= menu_held_next;
        power_held   <= power_held_next;
        select_held  <= select_held_next;
        start_held   <= start_held_next;
        repeat_phase <= repeat_phase_next;
        volume       <= volume_next;
        brightness   <= brightness_next;
        shut         <= shut_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign volume_level     = volume;
  assign brightness_level = brightness;
  assign shutdown_request = shut;

endmodule

// ===== sv/button_chord_level_control_core.sv =====
// Top level of the key-chord level control: front end, command queue and back end.
//
//  channel | signals                                    | flow
//  --------+--------------------------------------------+----------------------
//  events  | in_valid, in_stall, key_id, key_value      | into the block
//  results | out_valid, out_stall, volume_level,        | out of the block
//          | brightness_level, shutdown_request         |
//  config  | cfg_write, cfg_data                        | into the block
//
//  One event per cycle sustained while out_stall is low. An event enters the queue
//  at the edge it is taken; the back end registers its result from the queue
//  head once the result register is free or being taken.
//  The two-entry queue sets how far the front runs ahead of a stalled output.
//  rst is synchronous: levels, key flags, repeat toggle and model bit go to zero.
//  in_stall is high during reset and while the queue is full.
module button_chord_level_control_core #(
  parameter int MAX_VOLUME     = bclc_pkg::VOLUME_MAX_DEF,
  parameter int MAX_BRIGHTNESS = bclc_pkg::BRIGHTNESS_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [3:0]                        key_id,
  input  logic [1:0]                        key_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bclc_pkg::VOLUME_W-1:0]     volume_level,
  output logic [bclc_pkg::BRIGHTNESS_W-1:0] brightness_level,
  output logic                              shutdown_request
);
  import bclc_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_full, q_empty, q_push, q_pop;

  assign in_stall = rst || q_full;
  assign q_push   = in_valid && !in_stall;

  bclc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .key_id    (key_id),
    .key_value (key_value),
    .cmd       (front_cmd)
  );

  bclc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  bclc_back #(
    .MAX_VOLUME     (MAX_VOLUME),
    .MAX_BRIGHTNESS (MAX_BRIGHTNESS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd              (head_cmd),
    .cmd_avail        (!q_empty),
    .cmd_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .volume_level     (volume_level),
    .brightness_level (brightness_level),
    .shutdown_request (shutdown_request)
  );

endmodule

// ===== sv/bclc_checker.sv =====
// Port-level assertions for the key-chord level control, bound to the top level.
module bclc_checker #(
  parameter int MAX_VOLUME     = bclc_pkg::VOLUME_MAX_DEF,
  parameter int MAX_BRIGHTNESS = bclc_pkg::BRIGHTNESS_MAX_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bclc_pkg::VOLUME_W-1:0]     volume_level,
  input logic [bclc_pkg::BRIGHTNESS_W-1:0] brightness_level,
  input logic                              shutdown_request
);
  import bclc_pkg::*;

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(volume_level) &&
      $stable(brightness_level) && $stable(shutdown_request))
    else $error("stalled result changed");

  // Levels stay within their limits
  a_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (volume_level <= VOLUME_W'(MAX_VOLUME)) &&
      (brightness_level <= BRIGHTNESS_W'(MAX_BRIGHTNESS)))
    else $error("level beyond its limit");

  // Shutdown clears both flags, so the next transaction cannot repeat it
  a_single_shutdown: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && shutdown_request |=> !(out_valid && shutdown_request))
    else $error("shutdown on two transactions in a row");

endmodule

bind button_chord_level_control_core bclc_checker #(
  .MAX_VOLUME     (MAX_VOLUME),
  .MAX_BRIGHTNESS (MAX_BRIGHTNESS)
) u_bclc_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .volume_level     (volume_level),
  .brightness_level (brightness_level),
  .shutdown_request (shutdown_request)
);
